FILE: hw/rtl/ihex_pkg.sv
package ihex_pkg;

  typedef enum logic [2:0] {
    K_DATA   = 3'd0,
    K_OK     = 3'd1,
    K_BADSUM = 3'd2,
    K_ERROR  = 3'd3,
    K_END    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    E_NOCOLON  = 2'd0,
    E_EARLYEND = 2'd1,
    E_BADEOL   = 2'd2
  } err_t;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  // 'a'/'A' low nibble is 1; adding 9 gives 10
  localparam logic [3:0] ALPHA_ADJ  = 4'd9;
  localparam logic [15:0] LINE_MAX  = 16'hFFFF;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] record_address;
    logic [7:0]  record_type;
    logic [7:0]  record_length;
    err_t        error_code;
    logic [15:0] line_number;
  } result_t;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic alpha;
    alpha = ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) ||
            ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
    return alpha ? (c[3:0] + ALPHA_ADJ) : c[3:0];
  endfunction

endpackage

FILE: hw/rtl/ihex_if.sv
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

interface ihex_result_if;
  logic                valid;
  logic                ready;
  ihex_pkg::kind_t     kind;
  logic [7:0]          data_byte;
  logic [7:0]          byte_index;
  logic [15:0]         record_address;
  logic [7:0]          record_type;
  logic [7:0]          record_length;
  ihex_pkg::err_t      error_code;
  logic [15:0]         line_number;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output record_address, output record_type, output record_length,
                  output error_code, output line_number, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input record_address, input record_type, input record_length,
                  input error_code, input line_number, output ready);
endinterface

FILE: hw/rtl/ihex_parse.sv
module ihex_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          character,
  input  logic                end_of_input,
  output logic                emit,
  output ihex_pkg::result_t   res
);

  typedef enum logic [2:0] {
    PH_BEGIN, PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CRC, PH_LF, PH_HALT
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  nib_cnt, nib_cnt_next;
  logic [3:0]  hi_nib, hi_nib_next;
  logic [7:0]  len, len_next;
  logic [15:0] addr, addr_next;
  logic [7:0]  typ, typ_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  seen, seen_next;
  logic [15:0] lines, lines_next;

  logic [3:0]  d;
  logic [7:0]  pair;
  logic        second;
  logic [7:0]  seen_inc;

  ihex_pkg::kind_t kind;
  ihex_pkg::err_t  err;
  logic [7:0]      dbyte;
  logic [7:0]      idx;

  assign d        = ihex_pkg::digit_value(character);
  assign pair     = {hi_nib, d};
  assign second   = nib_cnt[0];
  assign seen_inc = seen + 8'd1;

  always_comb begin
    phase_next   = phase;
    nib_cnt_next = nib_cnt;
    hi_nib_next  = hi_nib;
    len_next     = len;
    addr_next    = addr;
    typ_next     = typ;
    sum_next     = sum;
    seen_next    = seen;
    lines_next   = lines;
    emit         = 1'b0;
    kind         = ihex_pkg::K_DATA;
    err          = ihex_pkg::E_NOCOLON;
    dbyte        = 8'd0;
    idx          = 8'd0;

    if (take && phase != PH_HALT) begin
      if (end_of_input) begin
        phase_next = PH_HALT;
        emit       = 1'b1;
        if (phase == PH_BEGIN || phase == PH_LF) begin
          kind = ihex_pkg::K_END;
        end else begin
          kind = ihex_pkg::K_ERROR;
          err  = ihex_pkg::E_EARLYEND;
        end
      end else begin
        unique case (phase)
          PH_BEGIN: begin
            if (character == ihex_pkg::CH_COLON) begin
              nib_cnt_next = 2'd0;
              hi_nib_next  = 4'd0;
              len_next     = 8'd0;
              addr_next    = 16'd0;
              typ_next     = 8'd0;
              sum_next     = 8'd0;
              seen_next    = 8'd0;
              if (lines != ihex_pkg::LINE_MAX) lines_next = lines + 16'd1;
              phase_next   = PH_LEN;
            end else begin
              phase_next = PH_HALT;
              emit       = 1'b1;
              kind       = ihex_pkg::K_ERROR;
              err        = ihex_pkg::E_NOCOLON;
            end
          end
          PH_LEN: begin
            if (!second) begin
              hi_nib_next  = d;
              nib_cnt_next = 2'd1;
            end else begin
              len_next     = pair;
              sum_next     = sum + pair;
              nib_cnt_next = 2'd0;
              phase_next   = PH_ADDR;
            end
          end
          PH_ADDR: begin
            addr_next = {addr[11:0], d};
            if (!second) hi_nib_next = d;
            else         sum_next = sum + pair;
            if (nib_cnt == 2'd3) begin
              nib_cnt_next = 2'd0;
              phase_next   = PH_TYPE;
            end else begin
              nib_cnt_next = nib_cnt + 2'd1;
            end
          end
          PH_TYPE: begin
            if (!second) begin
              hi_nib_next  = d;
              nib_cnt_next = 2'd1;
            end else begin
              typ_next     = pair;
              sum_next     = sum + pair;
              nib_cnt_next = 2'd0;
              phase_next   = (len == 8'd0) ? PH_CRC : PH_DATA;
            end
          end
          PH_DATA: begin
            if (!second) begin
              hi_nib_next  = d;
              nib_cnt_next = 2'd1;
            end else begin
              sum_next     = sum + pair;
              seen_next    = seen_inc;
              nib_cnt_next = 2'd0;
              if (seen_inc == len) phase_next = PH_CRC;
              emit  = 1'b1;
              kind  = ihex_pkg::K_DATA;
              dbyte = pair;
              idx   = seen;
            end
          end
          PH_CRC: begin
            if (!second) begin
              hi_nib_next  = d;
              nib_cnt_next = 2'd1;
            end else begin
              nib_cnt_next = 2'd0;
              phase_next   = PH_LF;
              emit         = 1'b1;
              kind         = (pair == (8'd0 - sum)) ? ihex_pkg::K_OK : ihex_pkg::K_BADSUM;
            end
          end
          PH_LF: begin
            if (character == ihex_pkg::CH_NEWLINE) begin
              nib_cnt_next = 2'd0;
              hi_nib_next  = 4'd0;
              len_next     = 8'd0;
              addr_next    = 16'd0;
              typ_next     = 8'd0;
              sum_next     = 8'd0;
              seen_next    = 8'd0;
              phase_next   = PH_BEGIN;
            end else begin
              phase_next = PH_HALT;
              emit       = 1'b1;
              kind       = ihex_pkg::K_ERROR;
              err        = ihex_pkg::E_BADEOL;
            end
          end
          PH_HALT: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    res.kind           = kind;
    res.data_byte      = dbyte;
    res.byte_index     = idx;
    res.record_address = addr;
    res.record_type    = typ;
    res.record_length  = len;
    res.error_code     = err;
    res.line_number    = lines;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_BEGIN;
      nib_cnt <= 2'd0;
      hi_nib  <= 4'd0;
      len     <= 8'd0;
      addr    <= 16'd0;
      typ     <= 8'd0;
      sum     <= 8'd0;
      seen    <= 8'd0;
      lines   <= 16'd0;
    end else begin
      phase   <= phase_next;
      nib_cnt <= nib_cnt_next;
      hi_nib  <= hi_nib_next;
      len     <= len_next;
      addr    <= addr_next;
      typ     <= typ_next;
      sum     <= sum_next;
      seen    <= seen_next;
      lines   <= lines_next;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("left halt without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |-> !emit)
    else $error("result emitted while halted");

  a_lines_monotonic: assert property (@(posedge clk) disable iff (rst)
    take |=> lines >= $past(lines))
    else $error("line counter went backwards");

  a_data_in_range: assert property (@(posedge clk) disable iff (rst)
    emit && kind == ihex_pkg::K_DATA |-> seen < len)
    else $error("data byte beyond record length");

endmodule

FILE: hw/rtl/ihex_out_reg.sv
module ihex_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ihex_pkg::result_t  din,
  output logic               space,
  ihex_result_if.source      result
);

  logic              valid;
  ihex_pkg::result_t data;

  assign space = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= din;
  end

  assign result.valid          = valid;
  assign result.kind           = data.kind;
  assign result.data_byte      = data.data_byte;
  assign result.byte_index     = data.byte_index;
  assign result.record_address = data.record_address;
  assign result.record_type    = data.record_type;
  assign result.record_length  = data.record_length;
  assign result.error_code     = data.error_code;
  assign result.line_number    = data.line_number;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> valid)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> space)
    else $error("pending result overwritten");

endmodule

FILE: hw/rtl/intel_hex_record_parser_core.sv
// Intel HEX record parser.
// stream: one text character per request (character, end_of_input).
// result: at most one item per request: data bytes as decoded, record
//   accepted or checksum failed after the checksum pair, error halt, or
//   clean end. Record fields and the saturating line count ride along.
// A request is decoded in the cycle it is taken; its result, if any, sits
//   in the output register and is valid the next cycle.
// One character is taken per cycle while the output register has space;
//   the output register frees in the same cycle its result is taken, so
//   stream.ready = !result.valid || result.ready.
// A stalled receiver holds the pending result; stream.ready drops until it
//   is taken. After an error or a clean end, characters are still taken but
//   give no result until rst.
// rst (synchronous) clears the parser to await a colon, zeroes all record
//   fields and the line count, and empties the output register.
module intel_hex_record_parser_core (
  input  logic          clk,
  input  logic          rst,
  ihex_char_if.sink     stream,
  ihex_result_if.source result
);

  logic              take;
  logic              emit;
  logic              space;
  ihex_pkg::result_t res;

  assign stream.ready = space;
  assign take         = stream.valid && space;

  ihex_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .character    (stream.character),
    .end_of_input (stream.end_of_input),
    .emit         (emit),
    .res          (res)
  );

  ihex_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (take && emit),
    .din    (res),
    .space  (space),
    .result (result)
  );

endmodule
